// File: sv/rrps_pkg.sv
// Shared types and constants of the round-robin / priority scheduler.
// Holds command codes, register indexes, the controller state type and
// the command and status structs between controller and datapath.
package rrps_pkg;

   localparam int CMD_W   = 2;
   localparam int PID_W   = 8;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 12;
   localparam int PRI_W   = 8;
   localparam int SLOT_W  = 16;
   localparam int CNT_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT   = 2'd2;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_RST_RD   = 10'b0000000010,
      ST_RST_WR   = 10'b0000000100,
      ST_SCAN_RD  = 10'b0000001000,
      ST_SCAN_CHK = 10'b0000010000,
      ST_PICK     = 10'b0000100000,
      ST_POP_RD   = 10'b0001000000,
      ST_POP_CHK  = 10'b0010000000,
      ST_RUN_RD   = 10'b0100000000,
      ST_RUN_EXE  = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic do_load;
      logic do_restart;
      logic do_advance;
      logic rst_wr;
      logic scan_chk;
      logic pick;
      logic pop_chk;
      logic run_rd;
      logic run_exe;
      logic emit_done;
      logic emit_idle;
   } ctrl_cmd_type;

   typedef struct packed {
      logic all_done;
      logic slice_zero;
      logic n_zero;
      logic scan_last;
      logic rst_last;
      logic fill_zero;
      logic fill_one;
      logic found;
      logic pop_live;
      logic policy;
   } dp_status_type;

endpackage

// File: sv/round_robin_priority_cpu_scheduler.sv
// Round-robin / non-preemptive priority CPU scheduler, at most one tick per advance.
// One transaction at a time. Load and unknown commands and an advance when all are done never
// go busy; a restart sweeps every table slot; an advance within a slice runs one step; a
// dispatch scans the active entries, picks, pops the FIFO as needed, and runs one if found.
// The result appears as busy falls, or with busy low when all are done; results cannot stall.
// Sync active-high reset clears run state; work reads as one until the first restart.
module round_robin_priority_cpu_scheduler
   import rrps_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int TIME_BITS     = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [3:0]            req_entry_index,
   input  logic [PID_W-1:0]      req_entry_pid,
   input  logic [ARR_W-1:0]      req_entry_arrival,
   input  logic [BURST_W-1:0]    req_entry_burst,
   input  logic [PRI_W-1:0]      req_entry_priority,
   output logic                  rsp_valid,
   output logic [SLOT_W-1:0]     rsp_slot_time,
   output logic [PID_W-1:0]      rsp_slot_pid,
   output logic                  rsp_slot_idle,
   output logic                  rsp_all_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencer.
   rrps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .busy        (busy),
      .cmd         (cmd)
   );

   // Tables, FIFO and timers.
   rrps_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_BITS     (TIME_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_entry_index    (req_entry_index),
      .req_entry_pid      (req_entry_pid),
      .req_entry_arrival  (req_entry_arrival),
      .req_entry_burst    (req_entry_burst),
      .req_entry_priority (req_entry_priority),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_slot_time      (rsp_slot_time),
      .rsp_slot_pid       (rsp_slot_pid),
      .rsp_slot_idle      (rsp_slot_idle),
      .rsp_all_done       (rsp_all_done)
   );

endmodule

// File: sv/rrps_ctrl.sv
// Controller state machine of the scheduler.
// Depends on rrps_pkg; drives the datapath by command bits only.
module rrps_ctrl
   import rrps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CMD_W-1:0]   req_command,
   input  dp_status_type      stat,
   output logic               busy,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOAD: begin
                     cmd.do_load = 1'b1;
                  end
                  CMD_RESTART: begin
                     cmd.do_restart = 1'b1;
                     state_in = ST_RST_RD;
                  end
                  CMD_ADVANCE: begin
                     cmd.do_advance = 1'b1;
                     if (stat.all_done) begin
                        cmd.emit_done = 1'b1;
                     end else if (!stat.slice_zero) begin
                        state_in = ST_RUN_RD;
                     end else if (stat.n_zero) begin
                        state_in = ST_PICK;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RST_RD: begin
            state_in = ST_RST_WR;
         end
         ST_RST_WR: begin
            cmd.rst_wr = 1'b1;
            state_in = stat.rst_last ? ST_IDLE : ST_RST_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            state_in = stat.scan_last ? ST_PICK : ST_SCAN_RD;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            if (!stat.policy) begin
               if (stat.fill_zero) begin
                  cmd.emit_idle = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_POP_RD;
               end
            end else if (stat.found) begin
               state_in = ST_RUN_RD;
            end else begin
               cmd.emit_idle = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_CHK;
         end
         ST_POP_CHK: begin
            cmd.pop_chk = 1'b1;
            if (stat.pop_live) begin
               state_in = ST_RUN_RD;
            end else if (stat.fill_one) begin
               cmd.emit_idle = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_POP_RD;
            end
         end
         ST_RUN_RD: begin
            cmd.run_rd = 1'b1;
            state_in = ST_RUN_EXE;
         end
         ST_RUN_EXE: begin
            cmd.run_exe = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/rrps_datapath.sv
// Datapath of the scheduler: process tables, ready FIFO, flags and timers.
// Depends on rrps_pkg; sequenced by rrps_ctrl through ctrl_cmd_type.
module rrps_datapath
   import rrps_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int TIME_BITS     = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         stat,
   input  logic [3:0]            req_entry_index,
   input  logic [PID_W-1:0]      req_entry_pid,
   input  logic [ARR_W-1:0]      req_entry_arrival,
   input  logic [BURST_W-1:0]    req_entry_burst,
   input  logic [PRI_W-1:0]      req_entry_priority,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic [SLOT_W-1:0]     rsp_slot_time,
   output logic [PID_W-1:0]      rsp_slot_pid,
   output logic                  rsp_slot_idle,
   output logic                  rsp_all_done
);

   localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam int SW = CW + 1;
   localparam int KW = (CW > CNT_W) ? CW : CNT_W;

   // Configuration registers.
   logic               policy_ff;
   logic [BURST_W-1:0] quantum_ff;
   logic [CNT_W-1:0]   count_ff;

   // Table memories and their registered read data.
   logic [ARR_W-1:0]   arr_mem   [MAX_PROCESSES];
   logic [PRI_W-1:0]   pri_mem   [MAX_PROCESSES];
   logic [PID_W-1:0]   pid_mem   [MAX_PROCESSES];
   logic [BURST_W-1:0] burst_mem [MAX_PROCESSES];
   logic [BURST_W-1:0] wl_mem    [MAX_PROCESSES];
   logic [IW-1:0]      fifo_mem  [MAX_PROCESSES];
   logic [ARR_W-1:0]   arr_q;
   logic [PRI_W-1:0]   pri_q;
   logic [PID_W-1:0]   pid_q;
   logic [BURST_W-1:0] burst_q;
   logic [BURST_W-1:0] wl_q;
   logic [IW-1:0]      fifo_q;

   // Run state.
   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;
   logic [MAX_PROCESSES-1:0] que_ff, que_in;
   logic [MAX_PROCESSES-1:0] wlv_ff, wlv_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [IW-1:0]        running_ff, running_in;
   logic [BURST_W-1:0]   slice_ff, slice_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [CW-1:0]        done_ff, done_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        best_ff, best_in;
   logic [PRI_W-1:0]     best_pri_ff, best_pri_in;
   logic                 found_ff, found_in;
   logic                 fresh_ff, fresh_in;

   // Helper signals.
   logic [IW-1:0]        tab_addr;
   logic                 ld_ok;
   logic [IW-1:0]        ld_addr;
   logic [CW-1:0]        n_act;
   logic [SW-1:0]        tail_sum;
   logic [IW-1:0]        tail;
   logic [IW-1:0]        head_inc;
   logic                 push_en;
   logic [IW-1:0]        push_e;
   logic                 wl_we;
   logic [IW-1:0]        wl_addr;
   logic [BURST_W-1:0]   wl_data;
   logic                 scan_ready;
   logic [BURST_W-1:0]   work;
   logic [BURST_W-1:0]   quantum_eff;
   logic [BURST_W-1:0]   slice_base;
   logic [BURST_W-1:0]   slice_dec;
   logic [BURST_W-1:0]   work_dec;
   logic                 slice_end;
   logic [TIME_BITS-1:0] tick_inc;
   logic [SLOT_W-1:0]    shown;

   assign ld_ok   = (32'(req_entry_index) < 32'(MAX_PROCESSES));
   assign ld_addr = IW'(req_entry_index);
   assign n_act   = (32'(count_ff) > 32'(MAX_PROCESSES)) ? CW'(MAX_PROCESSES)
                                                          : CW'(count_ff);
   assign tab_addr = cmd.run_rd ? running_ff : idx_ff;

   assign tail_sum = SW'(head_ff) + SW'(fill_ff);
   assign tail     = (tail_sum >= SW'(MAX_PROCESSES))
                     ? IW'(tail_sum - SW'(MAX_PROCESSES)) : IW'(tail_sum);
   assign head_inc = (head_ff == IW'(MAX_PROCESSES - 1)) ? '0 : head_ff + 1'b1;

   assign tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;
   assign shown    = (32'(tick_ff) > 32'hFFFF) ? 16'hFFFF : SLOT_W'(tick_ff);

   // Status toward the controller.
   always_comb begin
      stat.all_done   = (KW'(done_ff) >= KW'(count_ff));
      stat.slice_zero = (slice_ff == '0);
      stat.n_zero     = (n_act == '0);
      stat.scan_last  = ((CW'(idx_ff) + CW'(1)) == n_act);
      stat.rst_last   = (idx_ff == IW'(MAX_PROCESSES - 1));
      stat.fill_zero  = (fill_ff == '0);
      stat.fill_one   = (fill_ff == CW'(1));
      stat.found      = found_ff;
      stat.pop_live   = !fin_ff[fifo_q];
      stat.policy     = policy_ff;
   end

   // Scan and run step arithmetic.
   assign scan_ready  = !fin_ff[idx_ff] && (32'(arr_q) <= 32'(tick_ff));
   assign work        = wlv_ff[running_ff] ? wl_q : BURST_W'(1);
   assign quantum_eff = (quantum_ff == '0) ? BURST_W'(1) : quantum_ff;
   assign slice_base  = !fresh_ff ? slice_ff
                      : policy_ff ? work
                      : ((work < quantum_eff) ? work : quantum_eff);
   assign slice_dec   = slice_base - 1'b1;
   assign work_dec    = (work == '0) ? '0 : work - 1'b1;
   assign slice_end   = (slice_dec == '0) || (work_dec == '0);

   // Next values of the run state.
   always_comb begin
      fin_in      = fin_ff;
      que_in      = que_ff;
      wlv_in      = wlv_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      running_in  = running_ff;
      slice_in    = slice_ff;
      tick_in     = tick_ff;
      done_in     = done_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_pri_in = best_pri_ff;
      found_in    = found_ff;
      fresh_in    = fresh_ff;
      push_en     = 1'b0;
      push_e      = idx_ff;
      wl_we       = 1'b0;
      wl_addr     = idx_ff;
      wl_data     = burst_q;

      if (cmd.do_restart) begin
         fin_in     = '0;
         que_in     = '0;
         head_in    = '0;
         fill_in    = '0;
         running_in = '0;
         slice_in   = '0;
         tick_in    = '0;
         done_in    = '0;
         idx_in     = '0;
         fresh_in   = 1'b0;
      end
      if (cmd.do_advance) begin
         idx_in   = '0;
         found_in = 1'b0;
      end

      // Restart sweep copies each burst into the work counters.
      if (cmd.rst_wr) begin
         wl_we          = 1'b1;
         wlv_in[idx_ff] = 1'b1;
         idx_in         = idx_ff + 1'b1;
      end

      // One table entry examined per scan step.
      if (cmd.scan_chk) begin
         idx_in = idx_ff + 1'b1;
         if (!policy_ff) begin
            push_en = scan_ready && !que_ff[idx_ff];
         end else if (scan_ready && (!found_ff || (pri_q < best_pri_ff))) begin
            best_in     = idx_ff;
            best_pri_in = pri_q;
            found_in    = 1'b1;
         end
      end

      if (cmd.pick && policy_ff && found_ff) begin
         running_in = best_ff;
         fresh_in   = 1'b1;
      end

      // Pop the FIFO head; a finished entry is dropped.
      if (cmd.pop_chk) begin
         head_in        = head_inc;
         fill_in        = fill_ff - 1'b1;
         que_in[fifo_q] = 1'b0;
         if (!fin_ff[fifo_q]) begin
            running_in = fifo_q;
            fresh_in   = 1'b1;
         end
      end

      // One tick of work for the running entry.
      if (cmd.run_exe) begin
         fresh_in = 1'b0;
         tick_in  = tick_inc;
         wl_we    = 1'b1;
         wl_addr  = running_ff;
         wl_data  = work_dec;
         wlv_in[running_ff] = 1'b1;
         slice_in = slice_end ? '0 : slice_dec;
         if (work_dec == '0) begin
            if (!fin_ff[running_ff]) begin
               fin_in[running_ff] = 1'b1;
               done_in = done_ff + 1'b1;
            end
         end else if (slice_end && !que_ff[running_ff]) begin
            push_en = 1'b1;
            push_e  = running_ff;
         end
      end

      if (cmd.emit_idle) begin
         tick_in = tick_inc;
      end

      if (push_en && (fill_ff < CW'(MAX_PROCESSES))) begin
         fill_in        = fill_in + 1'b1;
         que_in[push_e] = 1'b1;
      end else begin
         push_en = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= 1'b0;
         quantum_ff  <= BURST_W'(4);
         count_ff    <= '0;
         fin_ff      <= '0;
         que_ff      <= '0;
         wlv_ff      <= '0;
         head_ff     <= '0;
         fill_ff     <= '0;
         running_ff  <= '0;
         slice_ff    <= '0;
         tick_ff     <= '0;
         done_ff     <= '0;
         idx_ff      <= '0;
         best_ff     <= '0;
         best_pri_ff <= '0;
         found_ff    <= 1'b0;
         fresh_ff    <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_POLICY:  policy_ff  <= csr_wdata[0];
               CSR_QUANTUM: quantum_ff <= csr_wdata;
               CSR_COUNT:   count_ff   <= csr_wdata[CNT_W-1:0];
               default: begin
               end
            endcase
         end
         fin_ff      <= fin_in;
         que_ff      <= que_in;
         wlv_ff      <= wlv_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         running_ff  <= running_in;
         slice_ff    <= slice_in;
         tick_ff     <= tick_in;
         done_ff     <= done_in;
         idx_ff      <= idx_in;
         best_ff     <= best_in;
         best_pri_ff <= best_pri_in;
         found_ff    <= found_in;
         fresh_ff    <= fresh_in;
         rsp_valid   <= cmd.emit_done || cmd.emit_idle || cmd.run_exe;
      end
   end

   // Result payload, captured with the current tick.
   always_ff @(posedge clock) begin
      if (cmd.emit_done || cmd.emit_idle || cmd.run_exe) begin
         rsp_slot_time <= shown;
         rsp_slot_pid  <= cmd.run_exe ? pid_q : '0;
         rsp_slot_idle <= cmd.emit_idle;
         rsp_all_done  <= cmd.emit_done;
      end
   end

   // Table memories: load port writes, one shared read address.
   always_ff @(posedge clock) begin
      if (cmd.do_load && ld_ok) begin
         pid_mem[ld_addr]   <= req_entry_pid;
         arr_mem[ld_addr]   <= req_entry_arrival;
         burst_mem[ld_addr] <= (req_entry_burst == '0) ? BURST_W'(1) : req_entry_burst;
         pri_mem[ld_addr]   <= req_entry_priority;
      end
      arr_q   <= arr_mem[tab_addr];
      pri_q   <= pri_mem[tab_addr];
      pid_q   <= pid_mem[tab_addr];
      burst_q <= burst_mem[tab_addr];
   end

   // Work counters.
   always_ff @(posedge clock) begin
      if (wl_we) begin
         wl_mem[wl_addr] <= wl_data;
      end
      wl_q <= wl_mem[tab_addr];
   end

   // Ready FIFO.
   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem[tail] <= push_e;
      end
      fifo_q <= fifo_mem[head_ff];
   end

   // Each queued entry is in the FIFO exactly once.
   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      $countones(que_ff) == int'(fill_ff))
      else $error("queued flags disagree with FIFO fill");

   // A slice in progress never belongs to a finished entry.
   a_slice_live: assert property (@(posedge clock) disable iff (reset)
      (slice_ff != '0) |-> !fin_ff[running_ff])
      else $error("slice left on a finished entry");

   // Completed count matches the finished flags.
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      $countones(fin_ff) == int'(done_ff))
      else $error("done count disagrees with finished flags");

   // A run step always yields a result in the next cycle.
   a_run_result: assert property (@(posedge clock) disable iff (reset)
      cmd.run_exe |=> (rsp_valid && !rsp_slot_idle && !rsp_all_done))
      else $error("run step without a result");

endmodule
